/* rtl/cfr_pkg.sv */
// Shared types and constants for the clock frame replacement block.
// Used by cfr_ctrl, cfr_dp and clock_frame_replacement; depends on nothing.
package cfr_pkg;

    localparam int FRAME_W        = 6;
    localparam int OP_W           = 2;
    localparam int STAT_W         = 3;
    localparam int CFG_W          = 7;
    localparam int FRAME_ID_LIMIT = 64;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_ACCESS  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Result status codes carried on the output tuser.
    localparam logic [STAT_W-1:0] ST_FRESH      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EVICTED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_VICTIM  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DONE       = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_LISTED = 3'd4;

    // How the list pointer moves in a cycle.
    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ZERO,
        POS_INC,
        POS_WRAP,
        POS_HAND
    } t_pos_op;

    // Source of the result frame.
    typedef enum logic [1:0] {
        RES_FRAME,
        RES_ZERO,
        RES_POS,
        RES_KEEP
    } t_res_sel;

    typedef struct packed {
        logic              cap;
        logic              set_ref;
        t_pos_op           pos_op;
        logic              take_fresh;
        logic              mark_del;
        logic              clr_ref_cur;
        logic              shift_wr;
        logic              unlink_rel;
        logic              free_frame;
        logic              evict_done;
        logic              wr_res;
        t_res_sel          res_sel;
        logic [STAT_W-1:0] stat;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            listed;
        logic            fresh_hit;
        logic            fresh_last;
        logic            len_zero;
        logic            match;
        logic            pos_last;
        logic            ref_cur;
        logic            shift_end;
        logic            out_free;
    } t_dp_sts;

endpackage

/* rtl/cfr_dp.sv */
// Datapath of the clock frame replacement block: order list memory, referenced
// and in-use bitmaps, list length, clock hand, scan pointer and result register.
// Depends on cfr_pkg; driven by commands from cfr_ctrl.
module cfr_dp #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cfr_pkg::t_dp_cmd               i_cmd,
    output cfr_pkg::t_dp_sts               o_sts,
    input  logic [cfr_pkg::OP_W-1:0]       i_op,
    input  logic [cfr_pkg::FRAME_W-1:0]    i_frame,
    input  logic [cfr_pkg::CFG_W-1:0]      i_pool_cfg,
    input  logic                           i_m_ready,
    output logic                           o_m_valid,
    output logic [cfr_pkg::FRAME_W-1:0]    o_m_frame,
    output logic [cfr_pkg::STAT_W-1:0]     o_m_stat
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int LW = $clog2(NUM_FRAMES + 1);

    logic [cfr_pkg::FRAME_W-1:0] r_mem [NUM_FRAMES];
    logic [cfr_pkg::FRAME_W-1:0] r_rdata;

    logic [cfr_pkg::OP_W-1:0]    r_op;
    logic [cfr_pkg::FRAME_W-1:0] r_frame;
    logic [LW-1:0]               r_pos;
    logic [LW-1:0]               n_pos;
    logic [AW-1:0]               r_del;
    logic [LW-1:0]               r_len;
    logic [AW-1:0]               r_hand;
    logic [NUM_FRAMES-1:0]       r_ref;
    logic [NUM_FRAMES-1:0]       r_in_use;
    logic [cfr_pkg::FRAME_W-1:0] r_res;
    logic [cfr_pkg::STAT_W-1:0]  r_stat;
    logic                        r_out_valid;
    logic [cfr_pkg::FRAME_W-1:0] r_out_frame;
    logic [cfr_pkg::STAT_W-1:0]  r_out_stat;

    logic [LW-1:0]               pool;
    logic [LW:0]                 pos_p1;
    logic [LW-1:0]               pos_m1;
    logic [LW-1:0]               len_m1;
    logic [AW-1:0]               frame_idx;
    logic [AW-1:0]               pos_idx;
    logic [AW-1:0]               rd_idx;
    logic [AW-1:0]               hand_dec;
    logic                        frame_ok;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [cfr_pkg::FRAME_W-1:0] mem_wdata;
    logic [cfr_pkg::FRAME_W-1:0] res_next;

    // Pool size saturates at the number of frames held.
    assign pool = (32'(i_pool_cfg) > NUM_FRAMES) ? LW'(NUM_FRAMES) : LW'(i_pool_cfg);

    assign pos_p1    = {1'b0, r_pos} + 1'b1;
    assign pos_m1    = r_pos - 1'b1;
    assign len_m1    = r_len - 1'b1;
    assign frame_idx = r_frame[AW-1:0];
    assign pos_idx   = r_pos[AW-1:0];
    assign rd_idx    = r_rdata[AW-1:0];
    assign frame_ok  = 32'(r_frame) < NUM_FRAMES;
    assign hand_dec  = (r_del < r_hand) ? r_hand - 1'b1 : r_hand;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.listed     = frame_ok && r_in_use[frame_idx];
        o_sts.fresh_hit  = (r_pos < pool) && !r_in_use[pos_idx];
        o_sts.fresh_last = pos_p1 >= {1'b0, pool};
        o_sts.len_zero   = r_len == '0;
        o_sts.match      = r_rdata == r_frame;
        o_sts.pos_last   = pos_p1 >= {1'b0, r_len};
        o_sts.ref_cur    = r_ref[rd_idx];
        o_sts.shift_end  = r_pos >= r_len;
        o_sts.out_free   = !r_out_valid || i_m_ready;
    end

    always_comb begin
        case (i_cmd.pos_op)
            cfr_pkg::POS_HOLD: n_pos = r_pos;
            cfr_pkg::POS_ZERO: n_pos = '0;
            cfr_pkg::POS_INC:  n_pos = pos_p1[LW-1:0];
            cfr_pkg::POS_WRAP: n_pos = (pos_p1 >= {1'b0, r_len}) ? '0 : pos_p1[LW-1:0];
            cfr_pkg::POS_HAND: n_pos = (LW'(r_hand) >= r_len) ? '0 : LW'(r_hand);
            default:           n_pos = r_pos;
        endcase
    end

    // Only one list write happens in any cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_len[AW-1:0];
        mem_wdata = cfr_pkg::FRAME_W'(r_pos);
        if (i_cmd.take_fresh) begin
            mem_we = r_len < LW'(NUM_FRAMES);
        end else if (i_cmd.shift_wr) begin
            mem_we    = 1'b1;
            mem_waddr = pos_m1[AW-1:0];
            mem_wdata = r_rdata;
        end else if (i_cmd.evict_done) begin
            mem_we    = 1'b1;
            mem_waddr = len_m1[AW-1:0];
            mem_wdata = r_res;
        end
    end

    always_comb begin
        case (i_cmd.res_sel)
            cfr_pkg::RES_FRAME: res_next = r_frame;
            cfr_pkg::RES_ZERO:  res_next = '0;
            cfr_pkg::RES_POS:   res_next = cfr_pkg::FRAME_W'(r_pos);
            cfr_pkg::RES_KEEP:  res_next = r_res;
            default:            res_next = r_res;
        endcase
    end

    // The read address follows the next pointer, so r_rdata is loaded at the same
    // edge as r_pos and holds the entry under the new pointer.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[n_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_cmd.cap) begin
            r_op    <= i_op;
            r_frame <= i_frame;
        end
        if (i_cmd.mark_del) begin
            r_del <= pos_idx;
            r_res <= r_rdata;
        end
        if (i_cmd.wr_res) begin
            r_res  <= res_next;
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.emit) begin
            r_out_frame <= r_res;
            r_out_stat  <= r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_hand      <= '0;
            r_ref       <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_ref) begin
                r_ref[frame_idx] <= 1'b1;
            end
            if (i_cmd.clr_ref_cur) begin
                r_ref[rd_idx] <= 1'b0;
            end
            if (i_cmd.take_fresh) begin
                r_in_use[pos_idx] <= 1'b1;
                r_ref[pos_idx]    <= 1'b0;
                if (r_len < LW'(NUM_FRAMES)) begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (i_cmd.unlink_rel) begin
                r_len  <= len_m1;
                r_hand <= (LW'(hand_dec) >= len_m1) ? '0 : hand_dec;
            end
            if (i_cmd.free_frame) begin
                r_in_use[frame_idx] <= 1'b0;
                r_ref[frame_idx]    <= 1'b0;
            end
            if (i_cmd.evict_done) begin
                r_ref[r_res[AW-1:0]] <= 1'b0;
                r_hand <= (LW'(r_del) < len_m1) ? r_del : '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_frame = r_out_frame;
    assign o_m_stat  = r_out_stat;

`ifndef SYNTHESIS
    a_len_matches_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) == 32'(r_len))
        else $error("list length differs from number of frames in use");

    a_hand_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (LW'(r_hand) < r_len))
        else $error("clock hand points past the list tail");

    a_hand_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_hand == '0))
        else $error("clock hand not at head of empty list");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_m_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

/* rtl/cfr_ctrl.sv */
// Controller of the clock frame replacement block: sequences decode, fresh
// frame search, clock scan, list search and list shift. Depends on cfr_pkg.
module cfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  cfr_pkg::t_dp_sts i_sts,
    output cfr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FRESH,
        S_SCAN,
        S_FIND,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.pos_op  = cfr_pkg::POS_HOLD;
        o_cmd.res_sel = cfr_pkg::RES_KEEP;
        o_cmd.stat    = cfr_pkg::ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    cfr_pkg::OP_ACCESS: begin
                        o_cmd.set_ref = i_sts.listed;
                        o_cmd.wr_res  = 1'b1;
                        o_cmd.res_sel = cfr_pkg::RES_FRAME;
                        o_cmd.stat    = i_sts.listed ? cfr_pkg::ST_DONE
                                                     : cfr_pkg::ST_NOT_LISTED;
                        n_state = S_FINISH;
                    end
                    cfr_pkg::OP_ALLOC: begin
                        o_cmd.pos_op = cfr_pkg::POS_ZERO;
                        n_state      = S_FRESH;
                    end
                    cfr_pkg::OP_RELEASE: begin
                        if (i_sts.listed) begin
                            o_cmd.pos_op = cfr_pkg::POS_ZERO;
                            n_state      = S_FIND;
                        end else begin
                            o_cmd.wr_res  = 1'b1;
                            o_cmd.res_sel = cfr_pkg::RES_FRAME;
                            o_cmd.stat    = cfr_pkg::ST_NOT_LISTED;
                            n_state       = S_FINISH;
                        end
                    end
                    default: begin
                        o_cmd.wr_res  = 1'b1;
                        o_cmd.res_sel = cfr_pkg::RES_FRAME;
                        o_cmd.stat    = cfr_pkg::ST_DONE;
                        n_state       = S_FINISH;
                    end
                endcase
            end
            S_FRESH: begin
                if (i_sts.fresh_hit) begin
                    o_cmd.take_fresh = 1'b1;
                    o_cmd.wr_res     = 1'b1;
                    o_cmd.res_sel    = cfr_pkg::RES_POS;
                    o_cmd.stat       = cfr_pkg::ST_FRESH;
                    n_state          = S_FINISH;
                end else if (i_sts.fresh_last) begin
                    if (i_sts.len_zero) begin
                        o_cmd.wr_res  = 1'b1;
                        o_cmd.res_sel = cfr_pkg::RES_ZERO;
                        o_cmd.stat    = cfr_pkg::ST_NO_VICTIM;
                        n_state       = S_FINISH;
                    end else begin
                        o_cmd.pos_op = cfr_pkg::POS_HAND;
                        n_state      = S_SCAN;
                    end
                end else begin
                    o_cmd.pos_op = cfr_pkg::POS_INC;
                end
            end
            S_SCAN: begin
                // A set bit gets its second chance; the first clear one is the victim.
                if (i_sts.ref_cur) begin
                    o_cmd.clr_ref_cur = 1'b1;
                    o_cmd.pos_op      = cfr_pkg::POS_WRAP;
                end else begin
                    o_cmd.mark_del = 1'b1;
                    o_cmd.pos_op   = cfr_pkg::POS_INC;
                    n_state        = S_SHIFT;
                end
            end
            S_FIND: begin
                if (i_sts.match) begin
                    o_cmd.mark_del = 1'b1;
                    o_cmd.pos_op   = cfr_pkg::POS_INC;
                    n_state        = S_SHIFT;
                end else if (i_sts.pos_last) begin
                    o_cmd.free_frame = 1'b1;
                    o_cmd.wr_res     = 1'b1;
                    o_cmd.res_sel    = cfr_pkg::RES_FRAME;
                    o_cmd.stat       = cfr_pkg::ST_DONE;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.pos_op = cfr_pkg::POS_INC;
                end
            end
            S_SHIFT: begin
                if (!i_sts.shift_end) begin
                    o_cmd.shift_wr = 1'b1;
                    o_cmd.pos_op   = cfr_pkg::POS_INC;
                end else if (i_sts.op == cfr_pkg::OP_RELEASE) begin
                    o_cmd.unlink_rel = 1'b1;
                    o_cmd.free_frame = 1'b1;
                    o_cmd.wr_res     = 1'b1;
                    o_cmd.res_sel    = cfr_pkg::RES_FRAME;
                    o_cmd.stat       = cfr_pkg::ST_DONE;
                    n_state          = S_FINISH;
                end else begin
                    // The victim goes back in at the tail, so the length is unchanged.
                    o_cmd.evict_done = 1'b1;
                    o_cmd.wr_res     = 1'b1;
                    o_cmd.res_sel    = cfr_pkg::RES_KEEP;
                    o_cmd.stat       = cfr_pkg::ST_EVICTED;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_cap_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |=> (r_state == S_DECODE))
        else $error("captured beat not followed by decode");

    a_emit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("result emitted without returning to idle");

    a_one_list_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.take_fresh, o_cmd.shift_wr, o_cmd.evict_done}) <= 1)
        else $error("two list writes requested in one cycle");
`endif

endmodule

/* rtl/clock_frame_replacement.sv */
// Top level of the clock frame replacement block: stream ports, APB register
// and the controller/datapath pair. Depends on cfr_pkg, cfr_ctrl and cfr_dp.
//
//  channel   | direction | tdata            | tuser
//  s_axis    | in        | [5:0] frame_index | [1:0] operation
//  m_axis    | out       | [5:0] result_frame| [2:0] status
//  apb       | in/out    | addr 0: frames_in_pool [6:0], reset 64
//
// Access and unlisted items are answered straight from decode. Allocate first
// searches the pool for a fresh frame, one in-use bit tested per cycle, and on
// an eviction then runs the clock scan and the list shift, one entry per cycle.
// Release searches the list for the frame and shifts the entries behind it, so
// the search and the shift pass each entry once.
// One beat is in work at a time; a finished result waits in the output
// register while the next beat is taken. A result that finds the output
// register still full waits, and the input stalls until the register is taken.
// Reset is synchronous and clears the list length, the bitmaps and the hand; the
// order list itself is not cleared.
module clock_frame_replacement #(
    parameter int MAX_FRAMES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] frame_index, [7:6] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] result_frame, [7:6] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NUM_FRAMES = (MAX_FRAMES < cfr_pkg::FRAME_ID_LIMIT) ?
                                MAX_FRAMES : cfr_pkg::FRAME_ID_LIMIT;
    localparam logic [0:0] REG_POOL = 1'b0;
    localparam logic [cfr_pkg::CFG_W-1:0] POOL_RESET = 7'd64;

    logic [cfr_pkg::CFG_W-1:0]   r_pool_cfg;
    cfr_pkg::t_dp_cmd            cmd;
    cfr_pkg::t_dp_sts            sts;
    logic [cfr_pkg::FRAME_W-1:0] out_frame;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_cfg <= POOL_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POOL)) begin
            r_pool_cfg <= pwdata[cfr_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_POOL) begin
            prdata = 32'(r_pool_cfg);
        end
    end

    cfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    cfr_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (s_axis_tuser),
        .i_frame    (s_axis_tdata[cfr_pkg::FRAME_W-1:0]),
        .i_pool_cfg (r_pool_cfg),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_frame  (out_frame),
        .o_m_stat   (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, out_frame};

endmodule

/* verif/clock_frame_replacement_tb.sv */
// Self-checking testbench for clock_frame_replacement: stream stimulus and
// APB pool writes, checked against a behavioral clock replacement predictor.
// Depends on cfr_pkg and the clock_frame_replacement RTL.
`timescale 1ns / 1ps

module clock_frame_replacement_tb;

    localparam int CLK_PERIOD     = 20;
    localparam int FRAMES         = 64;
    localparam int PHASES         = 10;
    localparam int PHASE_BEATS    = 150;
    localparam int LONG_HOLD      = 200;
    localparam int END_CYCLES     = 200;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    localparam logic [cfr_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
    localparam logic [2:0]               ADDR_POOL  = 3'd0;

    typedef struct packed {
        logic [cfr_pkg::OP_W-1:0]    op;
        logic [cfr_pkg::FRAME_W-1:0] frame;
    } t_request;

    typedef struct packed {
        logic [cfr_pkg::FRAME_W-1:0] frame;
        logic [cfr_pkg::STAT_W-1:0]  status;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [5:0] frame_index, [7:6] zero
    logic [1:0]  s_axis_tuser = 2'd0;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [5:0] result_frame, [7:6] zero
    logic [2:0]  m_axis_tuser;          // [2:0] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    clock_frame_replacement dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: the frame list from head to tail, the hand and the bitmaps.
    logic [cfr_pkg::FRAME_W-1:0] frame_order [FRAMES];
    int unsigned                 order_len;
    int unsigned                 hand_idx;
    logic                        ref_bit [FRAMES];
    logic                        in_use [FRAMES];
    logic [cfr_pkg::CFG_W-1:0]   pool_reg;

    t_request      pending_requests [$];
    t_frame_result expected_results [$];

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic void unlink_entry(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < order_len; i++) begin
            frame_order[i] = frame_order[i + 1];
        end
        order_len--;
    endfunction

    function automatic t_frame_result clock_step(input logic [cfr_pkg::OP_W-1:0] op,
                                                 input logic [cfr_pkg::FRAME_W-1:0] frame);
        t_frame_result res;
        int unsigned   pool;
        int unsigned   pos;
        int unsigned   i;
        int unsigned   steps;
        logic          found;
        logic [cfr_pkg::FRAME_W-1:0] victim;
        res.frame  = frame;
        res.status = cfr_pkg::ST_DONE;
        case (op)
            cfr_pkg::OP_ACCESS: begin
                if (in_use[frame]) ref_bit[frame] = 1'b1;
                else res.status = cfr_pkg::ST_NOT_LISTED;
            end
            cfr_pkg::OP_ALLOC: begin
                pool  = (pool_reg > cfr_pkg::FRAME_ID_LIMIT) ? cfr_pkg::FRAME_ID_LIMIT
                                                             : pool_reg;
                found = 1'b0;
                for (i = 0; i < pool && !found; i++) begin
                    if (!in_use[i]) begin
                        in_use[i]              = 1'b1;
                        ref_bit[i]             = 1'b0;
                        frame_order[order_len] = cfr_pkg::FRAME_W'(i);
                        order_len++;
                        res.frame  = cfr_pkg::FRAME_W'(i);
                        res.status = cfr_pkg::ST_FRESH;
                        found      = 1'b1;
                    end
                end
                if (!found && order_len == 0) begin
                    res.frame  = '0;
                    res.status = cfr_pkg::ST_NO_VICTIM;
                end else if (!found) begin
                    pos = (hand_idx >= order_len) ? 0 : hand_idx;
                    // Second chance: clear set bits until a clear one turns up.
                    // One full lap clears everything, so the loop is bounded.
                    steps = 0;
                    while (steps <= order_len && ref_bit[frame_order[pos]]) begin
                        ref_bit[frame_order[pos]] = 1'b0;
                        pos++;
                        if (pos >= order_len) pos = 0;
                        steps++;
                    end
                    victim = frame_order[pos];
                    unlink_entry(pos);
                    hand_idx               = (pos < order_len) ? pos : 0;
                    ref_bit[victim]        = 1'b0;
                    frame_order[order_len] = victim;
                    order_len++;
                    res.frame  = victim;
                    res.status = cfr_pkg::ST_EVICTED;
                end
            end
            cfr_pkg::OP_RELEASE: begin
                if (!in_use[frame]) begin
                    res.status = cfr_pkg::ST_NOT_LISTED;
                end else begin
                    pos = order_len;
                    for (i = 0; i < order_len && pos == order_len; i++) begin
                        if (frame_order[i] == frame) pos = i;
                    end
                    if (pos < order_len) begin
                        unlink_entry(pos);
                        // Keep the hand on the same frame when an earlier entry leaves.
                        if (pos < hand_idx) hand_idx--;
                        if (hand_idx >= order_len) hand_idx = 0;
                    end
                    in_use[frame]  = 1'b0;
                    ref_bit[frame] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Sender: predicts at each accepted beat, then offers the next pending item.
    int send_gap = 0;
    t_request next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(
                    clock_step(s_axis_tuser, s_axis_tdata[cfr_pkg::FRAME_W-1:0]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
                    send_gap = $urandom_range(1, 5) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, next_req.frame};
                    s_axis_tuser  <= next_req.op;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when one is requested.
    int stall_left = 0;
    int hold_left = 0;
    int hold_ack = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    t_frame_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected, frame",
                                int'(m_axis_tdata), -1);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== {2'b00, want.frame})
                    report_mismatch("result_frame", int'(m_axis_tdata), int'(want.frame));
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", int'(m_axis_tuser), int'(want.status));
            end
        end
    end

    task automatic add_request(input logic [cfr_pkg::OP_W-1:0] op, input int frame);
        t_request r;
        r.op    = op;
        r.frame = cfr_pkg::FRAME_W'(frame);
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_pool(input logic [cfr_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POOL;
        pwdata  <= {25'($urandom_range(0, 32'h01FF_FFFF)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        pool_reg = value;
        // The address stays on the pool register, so prdata shows the new value.
        @(negedge i_clk);
        if (prdata !== 32'(value))
            report_mismatch("pool register read back", int'(prdata), int'(value));
    endtask

    // Mostly well-formed traffic on frames the pool can hand out, with some
    // wide frame indices and the odd unused operation mixed in.
    function automatic t_request random_request(input int alloc_pct);
        t_request    r;
        int unsigned span;
        int unsigned pick;
        span = (pool_reg > cfr_pkg::FRAME_ID_LIMIT) ? cfr_pkg::FRAME_ID_LIMIT : pool_reg;
        if (span < 8) span = 8;
        pick    = $urandom_range(0, 99);
        r.frame = cfr_pkg::FRAME_W'($urandom_range(0, span - 1));
        if ($urandom_range(0, 9) == 0)
            r.frame = cfr_pkg::FRAME_W'($urandom_range(0, FRAMES - 1));
        if (pick < alloc_pct) begin
            r.op = cfr_pkg::OP_ALLOC;
        end else if (pick < alloc_pct + (100 - alloc_pct) / 2) begin
            r.op = cfr_pkg::OP_ACCESS;
        end else if (pick < 95) begin
            r.op = cfr_pkg::OP_RELEASE;
        end else begin
            r.op    = cfr_pkg::OP_W'($urandom_range(0, 3));
            r.frame = cfr_pkg::FRAME_W'($urandom_range(0, FRAMES - 1));
        end
        return r;
    endfunction

    initial begin : stimulus
        int unsigned phase_pool [PHASES];
        int          phase_alloc [PHASES];
        int          phase_idle [PHASES];
        int          p;
        int          n;
        phase_pool  = '{127, 1, 4, 8, 0, 64, 16, 2, 33, 6};
        phase_alloc = '{75, 40, 45, 40, 30, 70, 45, 40, 55, 45};
        phase_idle  = '{30, 0, 30, 50, 20, 30, 0, 30, 30, 0};

        order_len = 0;
        hand_idx  = 0;
        pool_reg  = 7'd64;
        for (n = 0; n < FRAMES; n++) begin
            frame_order[n] = '0;
            ref_bit[n]     = 1'b0;
            in_use[n]      = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset pool size.
        @(negedge i_clk);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        add_request(OP_IGNORED, 63);
        add_request(OP_IGNORED, 0);
        add_request(cfr_pkg::OP_ACCESS, 5);
        add_request(cfr_pkg::OP_RELEASE, 63);
        add_request(cfr_pkg::OP_ALLOC, 63);
        add_request(cfr_pkg::OP_ALLOC, 0);
        add_request(cfr_pkg::OP_ALLOC, 17);
        add_request(cfr_pkg::OP_ACCESS, 1);
        add_request(cfr_pkg::OP_ACCESS, 63);
        add_request(cfr_pkg::OP_RELEASE, 1);
        add_request(cfr_pkg::OP_ALLOC, 0);
        wait_drained;

        // Shrink below the frames in use: frame 2 stays listed, then evictions
        // including a scan where every bit is set.
        write_pool(7'd2);
        @(negedge i_clk);
        add_request(cfr_pkg::OP_ALLOC, 0);
        add_request(cfr_pkg::OP_ACCESS, 2);
        add_request(cfr_pkg::OP_ACCESS, 1);
        add_request(cfr_pkg::OP_ACCESS, 0);
        add_request(cfr_pkg::OP_ALLOC, 0);
        add_request(cfr_pkg::OP_RELEASE, 2);
        add_request(cfr_pkg::OP_RELEASE, 1);
        add_request(cfr_pkg::OP_RELEASE, 0);
        wait_drained;

        // Empty list and no pool at all: nothing to evict.
        write_pool(7'd0);
        @(negedge i_clk);
        add_request(cfr_pkg::OP_ALLOC, 42);
        wait_drained;

        for (p = 0; p < PHASES; p++) begin
            write_pool(cfr_pkg::CFG_W'(phase_pool[p]));
            @(negedge i_clk);
            tx_idle_pct = phase_idle[p];
            rx_idle_pct = phase_idle[p];
            for (n = 0; n < PHASE_BEATS; n++)
                pending_requests.push_back(random_request(phase_alloc[p]));
            // Back up the output so the block fills and stalls its input.
            if (p == 3) hold_req++;
            wait_drained;
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("clock_frame_replacement_tb: done, clean");
        end else begin
            $display("clock_frame_replacement_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout: results still outstanding");
        $display("clock_frame_replacement_tb: done, errors");
        $finish;
    end

endmodule
